/* rtl/srfo_pkg.sv */
// Shared types and constants for the section address translator.
package srfo_pkg;

    // Result status codes
    localparam logic [1:0] ST_MAPPED = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_BYTES  = 2'd0;
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd1;
    localparam logic [1:0] CFG_SECTIONS     = 2'd2;
    localparam logic [1:0] CFG_LOADED_MODE  = 2'd3;

    // Input selector
    localparam logic FUNC_LOAD      = 1'b0;
    localparam logic FUNC_TRANSLATE = 1'b1;

    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 40;

    // Section entry as stored: virtual and raw end addresses are kept at 33 bits
    typedef struct packed {
        logic [31:0] raw_start;
        logic [32:0] raw_end;
        logic [32:0] virt_end;
        logic [31:0] virt_base;
    } t_sect_entry;

    localparam int SECT_W = $bits(t_sect_entry);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_QEND      = 12'b000000000010,
        S_DECIDE    = 12'b000000000100,
        S_SCAN      = 12'b000000001000,
        S_FIN_DELTA = 12'b000000010000,
        S_FIN_POS   = 12'b000000100000,
        S_FIN_ADD   = 12'b000001000000,
        S_FIN_CHK   = 12'b000010000000,
        S_RESULT    = 12'b000100000000,
        S_LD_SPAN   = 12'b001000000000,
        S_LD_VEND   = 12'b010000000000,
        S_LD_WR     = 12'b100000000000
    } t_state;

endpackage

/* rtl/srfo_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module srfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/section_rva_to_file_offset_unit.sv */
// Section table address translator: top level with sequencer and shared adder.
//
// Channel   Dir  Signals                              Contents
// s_axis    in   tvalid/tready/tdata[199:0]/tuser     load entry or translate query
// m_axis    out  tvalid/tready/tdata[39:0]            file offset and status
// cfg       in   wr_en/index[1:0]/wdata[31:0]         image, header, count, mode
//
// A translate captures the query, forms its end and decides, then scans one entry
// per cycle (up to MAX_SECTIONS, via the table RAM read port); on a hit it steps
// through the shared 34-bit adder (delta, position, end) and a check to the result.
// A load forms span and virtual end, then writes the entry. Input is accepted
// only in idle; the result register holds until taken. Reset is synchronous and
// clears sequencer and configuration; the table has no reset and needs no clear pass.
module section_rva_to_file_offset_unit #(
    parameter int MAX_SECTIONS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tdata: entry_index[3:0], entry_virtual_base[35:4], entry_virtual_size[67:36],
    // entry_raw_size[99:68], entry_raw_start[131:100], query_address[163:132],
    // query_length[195:164], zero fill[199:196]
    input  logic [srfo_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: func[0]
    input  logic         i_s_axis_tuser,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: file_offset[31:0], status[33:32], zero fill[39:34]
    output logic [srfo_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata
);

    localparam int IW   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CW0  = $clog2(MAX_SECTIONS + 1);
    localparam int CNTW = (CW0 > 5) ? CW0 : 5;

    // Configuration
    logic [31:0]     r_image_bytes;
    logic [31:0]     r_header_bytes;
    logic [4:0]      r_sections;
    logic            r_loaded_mode;

    srfo_pkg::t_state r_state, n_state;

    // Captured item
    logic [3:0]      r_index;
    logic [31:0]     r_vbase;
    logic [31:0]     r_vsize;
    logic [31:0]     r_rsize;
    logic [31:0]     r_rstart;
    logic [31:0]     r_qaddr;
    logic [31:0]     r_qlen;

    // Working registers
    logic [32:0]     r_qend;
    logic [33:0]     r_acc;
    logic [32:0]     r_pos;
    logic [32:0]     r_vend;
    logic [31:0]     r_hit_base;
    logic [31:0]     r_hit_start;
    logic [IW-1:0]   r_idx;
    logic [CNTW-1:0] r_count;

    logic [31:0]     r_offset;
    logic [1:0]      r_status;
    logic            r_out_valid;

    // Shared adder
    logic [32:0]     add_a;
    logic [32:0]     add_b;
    logic            add_cin;
    logic [33:0]     add_sum;

    logic            s_accept;
    logic [CNTW-1:0] count_clamp;
    logic [CNTW-1:0] index_ext;
    logic            ld_slot_ok;
    logic            hdr_hit;
    logic            entry_cover;
    logic            entry_reject;
    logic            entry_last;
    logic [IW-1:0]   rd_addr;
    logic            ram_we;
    srfo_pkg::t_sect_entry wr_entry;
    srfo_pkg::t_sect_entry rd_entry;
    logic [srfo_pkg::SECT_W-1:0] rd_bits;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_bytes  <= '0;
            r_header_bytes <= '0;
            r_sections     <= '0;
            r_loaded_mode  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                srfo_pkg::CFG_IMAGE_BYTES:  r_image_bytes  <= i_cfg_wdata;
                srfo_pkg::CFG_HEADER_BYTES: r_header_bytes <= i_cfg_wdata;
                srfo_pkg::CFG_SECTIONS:     r_sections     <= i_cfg_wdata[4:0];
                srfo_pkg::CFG_LOADED_MODE:  r_loaded_mode  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (r_state)
            srfo_pkg::S_QEND: begin
                add_a = {1'b0, r_qaddr};
                add_b = {1'b0, r_qlen};
            end
            srfo_pkg::S_FIN_DELTA: begin
                add_a   = {1'b0, r_qaddr};
                add_b   = {1'b1, ~r_hit_base};
                add_cin = 1'b1;
            end
            srfo_pkg::S_FIN_POS: begin
                add_a = {1'b0, r_hit_start};
                add_b = {1'b0, r_acc[31:0]};
            end
            srfo_pkg::S_FIN_ADD: begin
                add_a = r_pos;
                add_b = {1'b0, r_qlen};
            end
            srfo_pkg::S_LD_VEND: begin
                add_a = {1'b0, r_vbase};
                add_b = {1'b0, r_acc[31:0]};
            end
            srfo_pkg::S_LD_WR: begin
                add_a = {1'b0, r_vbase};
                add_b = {1'b0, r_rsize};
            end
            default: ;
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {33'd0, add_cin};
    end

    assign count_clamp = (CNTW'(r_sections) > CNTW'(MAX_SECTIONS)) ?
                         CNTW'(MAX_SECTIONS) : CNTW'(r_sections);
    assign index_ext   = CNTW'(r_index);
    assign ld_slot_ok  = index_ext < CNTW'(MAX_SECTIONS);

    // Header rule; fitting the image reduces to the range end against the image size
    assign hdr_hit = (r_header_bytes <= r_image_bytes) && (r_qaddr < r_header_bytes) &&
                     (r_qend <= {1'b0, r_header_bytes}) &&
                     (r_qend <= {1'b0, r_image_bytes});

    assign rd_entry     = srfo_pkg::t_sect_entry'(rd_bits);
    // Covering: base <= addr < base+span and addr+len <= base+span
    assign entry_cover  = (r_qaddr >= rd_entry.virt_base) &&
                          ({1'b0, r_qaddr} < rd_entry.virt_end) &&
                          (r_qend <= rd_entry.virt_end);
    assign entry_reject = r_qend > rd_entry.raw_end;
    assign entry_last   = (CNTW'(r_idx) + CNTW'(1)) == r_count;

    always_comb begin
        if (r_state == srfo_pkg::S_SCAN) begin
            rd_addr = IW'(r_idx + 1'b1);
        end else begin
            rd_addr = '0;
        end
    end

    assign ram_we             = (r_state == srfo_pkg::S_LD_WR) && ld_slot_ok;
    assign wr_entry.raw_start = r_rstart;
    assign wr_entry.raw_end   = add_sum[32:0];
    assign wr_entry.virt_end  = r_vend;
    assign wr_entry.virt_base = r_vbase;

    srfo_ram #(
        .WIDTH (srfo_pkg::SECT_W),
        .DEPTH (MAX_SECTIONS)
    ) u_sect_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (index_ext[IW-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srfo_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_state = (i_s_axis_tuser == srfo_pkg::FUNC_TRANSLATE) ?
                              srfo_pkg::S_QEND : srfo_pkg::S_LD_SPAN;
                end
            end
            srfo_pkg::S_QEND:   n_state = srfo_pkg::S_DECIDE;
            srfo_pkg::S_DECIDE: begin
                if (r_loaded_mode || hdr_hit || count_clamp == '0) begin
                    n_state = srfo_pkg::S_RESULT;
                end else begin
                    n_state = srfo_pkg::S_SCAN;
                end
            end
            srfo_pkg::S_SCAN: begin
                if (entry_cover) begin
                    n_state = entry_reject ? srfo_pkg::S_RESULT : srfo_pkg::S_FIN_DELTA;
                end else if (entry_last) begin
                    n_state = srfo_pkg::S_RESULT;
                end
            end
            srfo_pkg::S_FIN_DELTA: n_state = srfo_pkg::S_FIN_POS;
            srfo_pkg::S_FIN_POS:   n_state = srfo_pkg::S_FIN_ADD;
            srfo_pkg::S_FIN_ADD:   n_state = srfo_pkg::S_FIN_CHK;
            srfo_pkg::S_FIN_CHK:   n_state = srfo_pkg::S_RESULT;
            srfo_pkg::S_RESULT: begin
                if (i_m_axis_tready) begin
                    n_state = srfo_pkg::S_IDLE;
                end
            end
            srfo_pkg::S_LD_SPAN: n_state = srfo_pkg::S_LD_VEND;
            srfo_pkg::S_LD_VEND: n_state = srfo_pkg::S_LD_WR;
            srfo_pkg::S_LD_WR:   n_state = srfo_pkg::S_IDLE;
            default:             n_state = srfo_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srfo_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (n_state == srfo_pkg::S_RESULT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_index  <= i_s_axis_tdata[3:0];
            r_vbase  <= i_s_axis_tdata[35:4];
            r_vsize  <= i_s_axis_tdata[67:36];
            r_rsize  <= i_s_axis_tdata[99:68];
            r_rstart <= i_s_axis_tdata[131:100];
            r_qaddr  <= i_s_axis_tdata[163:132];
            r_qlen   <= i_s_axis_tdata[195:164];
        end
        unique case (r_state)
            srfo_pkg::S_QEND: r_qend <= add_sum[32:0];
            srfo_pkg::S_DECIDE: begin
                r_count <= count_clamp;
                r_idx   <= '0;
                if (r_loaded_mode) begin
                    if (r_qend <= {1'b0, r_image_bytes}) begin
                        r_status <= srfo_pkg::ST_MAPPED;
                        r_offset <= r_qaddr;
                    end else begin
                        r_status <= srfo_pkg::ST_MISS;
                        r_offset <= '0;
                    end
                end else if (hdr_hit) begin
                    r_status <= srfo_pkg::ST_MAPPED;
                    r_offset <= r_qaddr;
                end else begin
                    r_status <= srfo_pkg::ST_MISS;
                    r_offset <= '0;
                end
            end
            srfo_pkg::S_SCAN: begin
                r_idx       <= IW'(r_idx + 1'b1);
                r_hit_base  <= rd_entry.virt_base;
                r_hit_start <= rd_entry.raw_start;
                if (entry_cover && entry_reject) begin
                    r_status <= srfo_pkg::ST_REJECT;
                end
            end
            srfo_pkg::S_FIN_DELTA: r_acc <= add_sum;
            srfo_pkg::S_FIN_POS:   r_pos <= add_sum[32:0];
            srfo_pkg::S_FIN_ADD:   r_acc <= add_sum;
            srfo_pkg::S_FIN_CHK: begin
                if (r_acc <= {2'b00, r_image_bytes}) begin
                    r_status <= srfo_pkg::ST_MAPPED;
                    r_offset <= r_pos[31:0];
                end else begin
                    r_status <= srfo_pkg::ST_REJECT;
                    r_offset <= '0;
                end
            end
            srfo_pkg::S_LD_SPAN: r_acc <= {2'b00, (r_vsize > r_rsize) ? r_vsize : r_rsize};
            srfo_pkg::S_LD_VEND: r_vend <= add_sum[32:0];
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == srfo_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_status, r_offset};

    // Result register is shown only while the sequencer parks in the result state
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid == (r_state == srfo_pkg::S_RESULT))
        else $error("result valid out of step with sequencer");

    // Offset is zero for any failed translate
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_status != srfo_pkg::ST_MAPPED) |-> r_offset == '0)
        else $error("nonzero offset on failed translate");

    // Status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_status == srfo_pkg::ST_MAPPED ||
                             r_status == srfo_pkg::ST_MISS ||
                             r_status == srfo_pkg::ST_REJECT))
        else $error("undefined status code");

    // One transaction at a time: input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("input still open after accept");

    // The scan never runs past the clamped entry count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srfo_pkg::S_SCAN) |-> (CNTW'(r_idx) < r_count))
        else $error("scan index beyond entry count");

endmodule
